### hw/rtl/assert_macros.svh
// Assertion macros shared by the gamepad remap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define GPR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gamepad remap: assertion failed");

// Condition must never be true outside reset.
`define GPR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gamepad remap: forbidden condition seen");

`else

`define GPR_ASSERT(lbl, clk, rst_n, prop)
`define GPR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/gprhd_pkg.sv
// Shared types, constants and register codes for the gamepad remapper.
package gprhd_pkg;

  // Stick scaling
  localparam int DEADZONE    = 20;
  localparam int AXIS_MAX    = 80;
  localparam int AXIS_DIAG   = 57;
  localparam int AXIS_CENTER = 128;
  localparam int POS_SPAN    = 127 - DEADZONE;
  localparam int NEG_SPAN    = 128 - DEADZONE;

  // Reciprocal multiply: floor(m*80/span) = (m * MULT) >> RECIP_SHIFT, exact for m <= span
  localparam int     RECIP_SHIFT = 30;
  localparam longint POS_RECIP   = ((longint'(1) << RECIP_SHIFT) + POS_SPAN - 1) / POS_SPAN;
  localparam longint NEG_RECIP   = ((longint'(1) << RECIP_SHIFT) + NEG_SPAN - 1) / NEG_SPAN;
  localparam logic [31:0] POS_MULT = 32'(AXIS_MAX * POS_RECIP);
  localparam logic [31:0] NEG_MULT = 32'(AXIS_MAX * NEG_RECIP);

  // Register reset values
  localparam logic [31:0] HOLD_TIME_RESET = 32'd3000000;
  localparam logic [31:0] TAP_TIME_RESET  = 32'd500000;

  // Register index codes (byte address / 4)
  typedef enum logic {
    REG_HOLD_TIME = 1'b0,
    REG_TAP_TIME  = 1'b1
  } cfg_reg_t;

  // D-pad directions from the source pad
  typedef struct packed {
    logic up;
    logic right;
    logic down;
    logic left;
  } dpad_t;

  // Select timer results for the current word
  typedef struct packed {
    logic c_right;
    logic fps;
  } sel_stat_t;

endpackage

### hw/rtl/gprhd_axis.sv
// One stick axis: deadzone and rescale of a raw 8-bit sample to -80..80.
module gprhd_axis
  import gprhd_pkg::*;
(
  input  logic [7:0]        raw,
  output logic signed [7:0] value
);

  logic       positive;
  logic [7:0] mag_c;
  logic [7:0] mag_m;
  logic [31:0] mult;
  logic [39:0] prod;
  logic [7:0] quot;

  // Split into side and distance from center
  always_comb begin
    positive = raw[7];
    mag_c    = positive ? {1'b0, raw[6:0]} : 8'(AXIS_CENTER) - raw;
    mag_m    = (mag_c < 8'(DEADZONE)) ? 8'd0 : mag_c - 8'(DEADZONE);
    mult     = positive ? POS_MULT : NEG_MULT;
  end

  // Scale by 80/span through a reciprocal multiply, truncating toward zero
  assign prod  = {32'd0, mag_m} * {8'd0, mult};
  assign quot  = prod[RECIP_SHIFT +: 8];
  assign value = positive ? $signed(quot) : -$signed(quot);

endmodule

### hw/rtl/gprhd_stick.sv
// Both stick axes with Y inversion and the D-pad override.
module gprhd_stick
  import gprhd_pkg::*;
(
  input  logic [7:0]        raw_x,
  input  logic [7:0]        raw_y,
  input  dpad_t             dpad,
  output logic signed [7:0] stick_x,
  output logic signed [7:0] stick_y
);

  logic signed [7:0] scaled_x;
  logic signed [7:0] scaled_y;
  logic              x_dir;
  logic              y_dir;
  logic signed [7:0] mag;

  gprhd_axis u_axis_x (
    .raw   (raw_x),
    .value (scaled_x)
  );

  gprhd_axis u_axis_y (
    .raw   (raw_y),
    .value (scaled_y)
  );

  // Pick stick or D-pad; opposite directions cancel on their axis
  always_comb begin
    x_dir = dpad.right ^ dpad.left;
    y_dir = dpad.up ^ dpad.down;
    mag   = (x_dir && y_dir) ? 8'(AXIS_DIAG) : 8'(AXIS_MAX);
    if (dpad.up || dpad.right || dpad.down || dpad.left) begin
      if (dpad.right && !dpad.left) begin
        stick_x = mag;
      end else if (dpad.left && !dpad.right) begin
        stick_x = -mag;
      end else begin
        stick_x = 8'sd0;
      end
      if (dpad.up && !dpad.down) begin
        stick_y = mag;
      end else if (dpad.down && !dpad.up) begin
        stick_y = -mag;
      end else begin
        stick_y = 8'sd0;
      end
    end else begin
      stick_x = scaled_x;
      stick_y = -scaled_y;
    end
  end

endmodule

### hw/rtl/gprhd_select.sv
// Select button timer: tap detection and hold toggle of the FPS flag.
`include "assert_macros.svh"

module gprhd_select
  import gprhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        select_btn,
  input  logic [31:0] now,
  input  logic [31:0] hold_time,
  input  logic [31:0] tap_time,
  output sel_stat_t   stat
);

  logic [31:0] press_start_r, press_start_nxt;
  logic        select_held_r, select_held_nxt;
  logic        hold_armed_r, hold_armed_nxt;
  logic        fps_flag_r, fps_flag_nxt;
  logic [31:0] elapsed;

  assign elapsed = now - press_start_r;

  // Work out the timer update for the word in flight
  always_comb begin
    press_start_nxt = press_start_r;
    select_held_nxt = select_held_r;
    hold_armed_nxt  = hold_armed_r;
    fps_flag_nxt    = fps_flag_r;
    stat.c_right    = 1'b0;
    if (select_btn) begin
      if (!select_held_r) begin
        select_held_nxt = 1'b1;
        press_start_nxt = now;
      end else if (hold_armed_r && (elapsed >= hold_time)) begin
        fps_flag_nxt   = !fps_flag_r;
        hold_armed_nxt = 1'b0;
      end
    end else begin
      stat.c_right    = select_held_r && hold_armed_r && (elapsed < tap_time);
      select_held_nxt = 1'b0;
      press_start_nxt = 32'd0;
      hold_armed_nxt  = 1'b1;
    end
    stat.fps = fps_flag_nxt;
  end

  // Commit only when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= 32'd0;
      select_held_r <= 1'b0;
      hold_armed_r  <= 1'b1;
      fps_flag_r    <= 1'b0;
    end else if (step) begin
      press_start_r <= press_start_nxt;
      select_held_r <= select_held_nxt;
      hold_armed_r  <= hold_armed_nxt;
      fps_flag_r    <= fps_flag_nxt;
    end
  end

  `GPR_NEVER(a_disarm_needs_press, clk, rst_n, !hold_armed_r && !select_held_r)
  `GPR_ASSERT(a_idle_start_zero, clk, rst_n, !select_held_r |-> (press_start_r == 32'd0))
  `GPR_ASSERT(a_fps_toggle_on_hold, clk, rst_n, ($past(rst_n) && (fps_flag_r != $past(fps_flag_r))) |-> $past(step && select_btn && select_held_r && hold_armed_r))

endmodule

### hw/rtl/gamepad_remap_with_hold_detect.sv
// Top level of the gamepad remapper: stream ports, register port and the two-register pipeline.
// Takes one controller word per clock and returns one pad word for each. A word accepted into
// the input register crosses the button remap, the select timer and the stick scalers (one
// reciprocal multiply per axis) into the result register once that register is free or being
// drained, and is offered on the output stream from there. While a finished result waits, the
// input register can still take one more word; after that in_tready stays low until the result
// is taken. Throughput is one word per cycle whenever the output side takes one per cycle.
// Select timing uses time_us from the word itself; hold_time_us (0x0) and tap_time_us (0x4) are
// written over the APB-style port, and the user must write them only while the stream is idle;
// the block itself has no check for this.
`include "assert_macros.svh"

module gamepad_remap_with_hold_detect
  import gprhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // src_buttons[15:0], raw_x[23:16], raw_y[31:24], time_us[63:32]
  input  logic        in_tuser,   // in_menu[0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pad_buttons[15:0], stick_x[23:16], stick_y[31:24],
                                  // fps_shown[32], zero[39:33]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] hold_time_r;
  logic [31:0] tap_time_r;
  cfg_reg_t    cfg_sel;
  logic        cfg_wr;

  logic        s1_valid_r;
  logic [15:0] s1_buttons_r;
  logic [7:0]  s1_raw_x_r;
  logic [7:0]  s1_raw_y_r;
  logic [31:0] s1_time_r;
  logic        s1_menu_r;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] pad_r, pad_nxt;
  logic [7:0]  stick_x_r;
  logic [7:0]  stick_y_r;
  logic        fps_r;

  logic              advance;
  sel_stat_t         sel_stat;
  dpad_t             dpad;
  logic signed [7:0] stick_x;
  logic signed [7:0] stick_y;

  // Register port decode
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_TIME_RESET;
      tap_time_r  <= TAP_TIME_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_HOLD_TIME: hold_time_r <= cfg_pwdata;
        REG_TAP_TIME:  tap_time_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_HOLD_TIME: cfg_prdata = hold_time_r;
      REG_TAP_TIME:  cfg_prdata = tap_time_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline handshake: advance when the result register is free or being drained
  assign advance       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !s1_valid_r || advance;
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_buttons_r <= in_tdata[15:0];
      s1_raw_x_r   <= in_tdata[23:16];
      s1_raw_y_r   <= in_tdata[31:24];
      s1_time_r    <= in_tdata[63:32];
      s1_menu_r    <= in_tuser;
    end
  end

  // Select timer
  gprhd_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .select_btn (s1_buttons_r[0]),
    .now        (s1_time_r),
    .hold_time  (hold_time_r),
    .tap_time   (tap_time_r),
    .stat       (sel_stat)
  );

  // Stick path
  assign dpad.up    = s1_buttons_r[4];
  assign dpad.right = s1_buttons_r[5];
  assign dpad.down  = s1_buttons_r[6];
  assign dpad.left  = s1_buttons_r[7];

  gprhd_stick u_stick (
    .raw_x   (s1_raw_x_r),
    .raw_y   (s1_raw_y_r),
    .dpad    (dpad),
    .stick_x (stick_x),
    .stick_y (stick_y)
  );

  // Button remap to the target pad word
  always_comb begin
    pad_nxt     = 16'd0;
    pad_nxt[15] = s1_buttons_r[14];
    pad_nxt[14] = s1_buttons_r[15];
    pad_nxt[13] = s1_buttons_r[13] || s1_buttons_r[8];
    pad_nxt[12] = s1_buttons_r[3];
    pad_nxt[11] = s1_buttons_r[4];
    pad_nxt[10] = s1_buttons_r[6];
    pad_nxt[9]  = s1_buttons_r[7];
    pad_nxt[8]  = s1_buttons_r[5];
    pad_nxt[5]  = s1_buttons_r[8] && s1_menu_r;
    pad_nxt[4]  = s1_buttons_r[9];
    pad_nxt[3]  = s1_buttons_r[12];
    pad_nxt[0]  = sel_stat.c_right;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pad_r     <= pad_nxt;
      stick_x_r <= stick_x;
      stick_y_r <= stick_y;
      fps_r     <= sel_stat.fps;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, fps_r, stick_y_r, stick_x_r, pad_r};

  `GPR_ASSERT(a_stall_blocks_input, clk, rst_n, (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
  `GPR_ASSERT(a_empty_stage_ready, clk, rst_n, !s1_valid_r |-> in_tready)
  `GPR_ASSERT(a_advance_fills_out, clk, rst_n, advance |=> out_valid_r)

endmodule

### tb/tb_gamepad_remap_with_hold_detect.sv
// Self-checking testbench for the gamepad remapper with select hold detection.
`timescale 1ns / 1ps

// Expected pad word for one controller sample
typedef struct {
  logic [15:0]        pad;
  logic signed [7:0]  sx;
  logic signed [7:0]  sy;
  logic               fps;
} pad_word_t;

// Scoreboard: tracks select timing and the registers, queues expected pad words
class pad_word_board;
  localparam int DEAD_BAND = 20;
  localparam int FULL_TILT = 80;
  localparam int DIAG_TILT = 57;

  logic [31:0] hold_us;
  logic [31:0] tap_us;
  logic [31:0] press_t;
  bit          sel_held;
  bit          armed;
  bit          fps;
  pad_word_t   pending_pads[$];
  int          mismatches;

  function new();
    hold_us    = 32'd3000000;
    tap_us     = 32'd500000;
    press_t    = '0;
    sel_held   = 0;
    armed      = 1;
    fps        = 0;
    mismatches = 0;
  endfunction

  function void set_reg(gprhd_pkg::cfg_reg_t idx, logic [31:0] v);
    if (idx == gprhd_pkg::REG_HOLD_TIME) hold_us = v;
    else tap_us = v;
  endfunction

  // Deadzone, then rescale with truncating division
  function int axis_scale(logic [7:0] raw);
    int c;
    c = int'(raw) - 128;
    if (c > -DEAD_BAND && c < DEAD_BAND) return 0;
    if (c > 0) c = (c - DEAD_BAND) * FULL_TILT / (127 - DEAD_BAND);
    else c = (c + DEAD_BAND) * FULL_TILT / (128 - DEAD_BAND);
    if (c > FULL_TILT) c = FULL_TILT;
    else if (c < -FULL_TILT) c = -FULL_TILT;
    return c;
  endfunction

  // Predict the pad word for an accepted controller word
  function void note_sample(logic [63:0] d, logic menu);
    logic [15:0] btn;
    logic [31:0] now;
    logic [31:0] elapsed;
    pad_word_t   w;
    int          sx, sy, dx, dy, mag;
    btn     = d[15:0];
    now     = d[63:32];
    elapsed = now - press_t;
    w.pad   = '0;
    // Select timer: tap on early release, toggle on long hold
    if (btn[0]) begin
      if (!sel_held) begin
        sel_held = 1;
        press_t  = now;
      end else if (armed && elapsed >= hold_us) begin
        fps   = !fps;
        armed = 0;
      end
    end else begin
      if (sel_held && armed && elapsed < tap_us) w.pad[0] = 1'b1;
      sel_held = 0;
      press_t  = '0;
      armed    = 1;
    end
    // Button remap
    w.pad[15] = btn[14];
    w.pad[14] = btn[15];
    w.pad[13] = btn[13] | btn[8];
    w.pad[5]  = btn[8] & menu;
    w.pad[4]  = btn[9];
    w.pad[3]  = btn[12];
    w.pad[12] = btn[3];
    w.pad[11] = btn[4];
    w.pad[10] = btn[6];
    w.pad[9]  = btn[7];
    w.pad[8]  = btn[5];
    // Sticks, with D-pad override
    sx = axis_scale(d[23:16]);
    sy = -axis_scale(d[31:24]);
    if (|btn[7:4]) begin
      dx  = int'(btn[5]) - int'(btn[7]);
      dy  = int'(btn[4]) - int'(btn[6]);
      mag = (dx != 0 && dy != 0) ? DIAG_TILT : FULL_TILT;
      sx  = dx * mag;
      sy  = dy * mag;
    end
    w.sx  = sx[7:0];
    w.sy  = sy[7:0];
    w.fps = fps;
    pending_pads.push_back(w);
  endfunction

  // Compare one result word with the oldest prediction
  function void check_pad_word(logic [39:0] d);
    pad_word_t w;
    if (pending_pads.size() == 0) begin
      $display("%0t: unexpected result word, actual %h", $time, d);
      mismatches++;
      return;
    end
    w = pending_pads.pop_front();
    if (d[15:0] !== w.pad) begin
      $display("%0t: pad_buttons expected %h actual %h", $time, w.pad, d[15:0]);
      mismatches++;
    end
    if (d[23:16] !== w.sx) begin
      $display("%0t: stick_x expected %0d actual %0d", $time, w.sx, $signed(d[23:16]));
      mismatches++;
    end
    if (d[31:24] !== w.sy) begin
      $display("%0t: stick_y expected %0d actual %0d", $time, w.sy, $signed(d[31:24]));
      mismatches++;
    end
    if (d[32] !== w.fps) begin
      $display("%0t: fps_shown expected %b actual %b", $time, w.fps, d[32]);
      mismatches++;
    end
    if (d[39:33] !== 7'd0) begin
      $display("%0t: pad bits expected 00 actual %h", $time, d[39:33]);
      mismatches++;
    end
  endfunction
endclass

module tb_gamepad_remap_with_hold_detect;
  import gprhd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // src_buttons[15:0], raw_x[23:16], raw_y[31:24], time_us[63:32]
  logic        in_tuser;   // in_menu[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // pad_buttons[15:0], stick_x[23:16], stick_y[31:24], fps_shown[32]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pad_word_board board;
  int          cycles;
  bit          idle_on;
  bit          hold_off_req;
  logic [31:0] sample_t;
  bit          sel_pressed;
  int          sel_left;

  gamepad_remap_with_hold_detect i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cycle counter with run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Note accepted words and check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_sample(in_tdata, in_tuser);
      if (out_tvalid && out_tready) board.check_pad_word(out_tdata);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one controller word after an optional gap, hold until accepted
  task automatic drive_sample(logic [15:0] b, logic [7:0] x, logic [7:0] y,
                              logic [31:0] t, logic m, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, y, x, b};
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 5) == 0) return $urandom_range(1, 13);
    return 0;
  endfunction

  task automatic push_dir(logic [15:0] b, logic [7:0] x, logic [7:0] y,
                          logic [31:0] t, logic m);
    drive_sample(b, x, y, t, m, pick_gap());
  endtask

  // Drop valid and wait until every result has been taken
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending_pads.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a register, then read it back in the next transfer
  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== v) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, v, cfg_prdata);
      board.mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random words: mostly well-formed select presses, some noise
  task automatic run_phase(int n, logic [31:0] tstep, bit with_hold_off);
    logic [15:0] b;
    int          gap;
    for (int i = 0; i < n; i++) begin
      if (sel_left == 0) begin
        sel_pressed = !sel_pressed;
        sel_left = sel_pressed ? $urandom_range(1, 10) : $urandom_range(1, 4);
      end
      sel_left--;
      b = 16'($urandom);
      if ($urandom_range(0, 1) == 0) b[7:4] = 4'b0000;
      if ($urandom_range(0, 7) != 0) b[0] = sel_pressed;
      case ($urandom_range(0, 15))
        0: sample_t = $urandom;
        1: ;
        default: sample_t = sample_t + $urandom_range(0, tstep);
      endcase
      gap = pick_gap();
      if (with_hold_off && i == 30) hold_off_req = 1;
      if (with_hold_off && i >= 30 && i < 90) gap = 0;
      drive_sample(b, pick_axis(), pick_axis(), sample_t, 1'($urandom_range(0, 1)), gap);
    end
  endtask

  initial begin
    board        = new();
    cycles       = 0;
    idle_on      = 1;
    hold_off_req = 0;
    sample_t     = '0;
    sel_pressed  = 0;
    sel_left     = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Axis extremes and deadzone edges
    push_dir(16'h0000, 8'd128, 8'd128, 32'd0,   1'b0);
    push_dir(16'h0000, 8'd0,   8'd255, 32'd100, 1'b0);
    push_dir(16'h0000, 8'd255, 8'd0,   32'd200, 1'b1);
    push_dir(16'h0000, 8'd108, 8'd148, 32'd300, 1'b0);
    push_dir(16'h0000, 8'd107, 8'd149, 32'd400, 1'b0);
    push_dir(16'h0000, 8'd129, 8'd127, 32'd500, 1'b0);
    // All buttons but select, in and out of menu; L trigger alone
    push_dir(16'hFFFE, 8'd200, 8'd50,  32'd600, 1'b1);
    push_dir(16'hFFFE, 8'd200, 8'd50,  32'd700, 1'b0);
    push_dir(16'h0100, 8'd128, 8'd128, 32'd800, 1'b1);
    push_dir(16'h0100, 8'd128, 8'd128, 32'd900, 1'b0);
    // D-pad: straight, diagonal, opposite directions cancel
    push_dir(16'h0010, 8'd0,   8'd0,   32'd910, 1'b0);
    push_dir(16'h0030, 8'd0,   8'd0,   32'd920, 1'b0);
    push_dir(16'h0050, 8'd255, 8'd255, 32'd930, 1'b0);
    push_dir(16'h00C0, 8'd128, 8'd128, 32'd940, 1'b0);
    push_dir(16'h00F0, 8'd30,  8'd220, 32'd950, 1'b0);
    push_dir(16'h00A0, 8'd30,  8'd220, 32'd960, 1'b0);
    // Short select press gives a tap
    push_dir(16'h0001, 8'd128, 8'd128, 32'd1000, 1'b0);
    push_dir(16'h0001, 8'd128, 8'd128, 32'd2000, 1'b0);
    push_dir(16'h0000, 8'd128, 8'd128, 32'd3000, 1'b0);
    // Long hold toggles once, then no tap on release
    push_dir(16'h0001, 8'd128, 8'd128, 32'd10000,   1'b0);
    push_dir(16'h0001, 8'd128, 8'd128, 32'd3010000, 1'b0);
    push_dir(16'h0001, 8'd128, 8'd128, 32'd6020000, 1'b0);
    push_dir(16'h0000, 8'd128, 8'd128, 32'd6100000, 1'b0);
    // Press across the time wrap
    push_dir(16'h0001, 8'd128, 8'd128, 32'hFFFFFF00, 1'b0);
    push_dir(16'h0000, 8'd128, 8'd128, 32'h00000100, 1'b0);
    // Press exactly as long as the tap time is no tap
    push_dir(16'h0001, 8'd128, 8'd128, 32'h10000000, 1'b0);
    push_dir(16'h0000, 8'd128, 8'd128, 32'h10000000 + 32'd500000, 1'b0);
    settle();

    // Reset register values
    run_phase(240, 32'd1200000, 0);
    settle();

    // Zero hold and tap times
    write_reg(REG_HOLD_TIME, 32'd0);
    write_reg(REG_TAP_TIME, 32'd0);
    run_phase(240, 32'd1000, 0);
    settle();

    // Largest hold and tap times
    write_reg(REG_HOLD_TIME, 32'hFFFFFFFF);
    write_reg(REG_TAP_TIME, 32'hFFFFFFFF);
    run_phase(240, 32'hFFFFFFFF, 0);
    settle();

    // Short times near the wrap, with a long receiver hold-off
    write_reg(REG_HOLD_TIME, 32'd1000);
    write_reg(REG_TAP_TIME, 32'd300);
    sample_t = 32'hFFFFF000;
    run_phase(240, 32'd400, 1);
    settle();

    // Random registers, no idling on either side
    write_reg(REG_HOLD_TIME, $urandom_range(0, 5000));
    write_reg(REG_TAP_TIME, $urandom_range(0, 3000));
    idle_on = 0;
    run_phase(240, 32'd1500, 0);
    settle();
    repeat (10) @(negedge clk);

    if (board.mismatches == 0 && board.pending_pads.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gprhd_pkg.sv
hw/rtl/gprhd_axis.sv
hw/rtl/gprhd_stick.sv
hw/rtl/gprhd_select.sv
hw/rtl/gamepad_remap_with_hold_detect.sv
tb/tb_gamepad_remap_with_hold_detect.sv
